/* rtl/wmf_pkg.sv */
// Shared constants and types of the windowed median filter.
// No dependencies; the lane, merge and top-level files import this package.
package wmf_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int WORD_W     = PIX_W * NUM_CH;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_W      = 16;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_WIN_DEF   = 5;

  localparam logic [10:0] IMG_W_RST = 11'd640;
  localparam logic [15:0] IMG_H_RST = 16'd480;
  localparam logic [2:0]  WIN_RST   = 3'd3;
  localparam logic [2:0]  CTR_RST   = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_WINDOW_WIDTH  = 3'd2,
    CFG_WINDOW_HEIGHT = 3'd3,
    CFG_CENTER_X      = 3'd4,
    CFG_CENTER_Y      = 3'd5,
    CFG_COLOR_MODE    = 3'd6
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

/* rtl/wmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wmf_lane.sv */
// One channel lane: ranks one window element per cycle while en_i is high and keeps the two middle values.
// Depends on wmf_pkg.
module wmf_lane #(
  parameter int NumElem = 25
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [(NumElem>1 ? $clog2(NumElem) : 1)-1:0] idx_i,
  input  wmf_pkg::pix_t                    elems_i [NumElem],
  input  logic [NumElem-1:0]               mask_i,
  input  logic [$clog2(NumElem+1)-1:0]     p_lo_i,
  input  logic [$clog2(NumElem+1)-1:0]     p_hi_i,
  output wmf_pkg::pix_t                    lo_o,
  output wmf_pkg::pix_t                    hi_o
);
  import wmf_pkg::*;

  localparam int CNT_W = $clog2(NumElem + 1);

  pix_t               cand;
  logic [NumElem-1:0] less_v, eq_v;
  logic [CNT_W:0]     less_c, upper_c;
  logic               hit_lo, hit_hi;
  pix_t               lo_q, hi_q;

  assign cand = elems_i[idx_i];

  always_comb begin
    for (int e = 0; e < NumElem; e++) begin
      less_v[e] = mask_i[e] && (elems_i[e] < cand);
      eq_v[e]   = mask_i[e] && (elems_i[e] == cand);
    end
  end

  // The candidate covers the sorted positions from less_c up to upper_c - 1.
  assign less_c  = (CNT_W+1)'($countones(less_v));
  assign upper_c = less_c + (CNT_W+1)'($countones(eq_v));
  assign hit_lo  = mask_i[idx_i] && (less_c <= {1'b0, p_lo_i}) && ({1'b0, p_lo_i} < upper_c);
  assign hit_hi  = mask_i[idx_i] && (less_c <= {1'b0, p_hi_i}) && ({1'b0, p_hi_i} < upper_c);

  always_ff @(posedge clk_i) begin
    if (en_i && hit_lo) begin
      lo_q <= cand;
    end
    if (en_i && hit_hi) begin
      hi_q <= cand;
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

/* rtl/wmf_merge.sv */
// Merges the lane results into the channel medians; channels 1 and 2 are zero unless color_i is set.
// Depends on wmf_pkg.
module wmf_merge (
  input  wmf_pkg::pix_t lo_i  [wmf_pkg::NUM_CH],
  input  wmf_pkg::pix_t hi_i  [wmf_pkg::NUM_CH],
  input  logic          color_i,
  output wmf_pkg::pix_t med_o [wmf_pkg::NUM_CH]
);
  import wmf_pkg::*;

  logic [PIX_W:0] sum [NUM_CH];

  // For an odd count both middle values are the same element, so the mean is exact.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = {1'b0, lo_i[c]} + {1'b0, hi_i[c]};
      if (c == 0 || color_i) begin
        med_o[c] = sum[c][PIX_W:1];
      end else begin
        med_o[c] = '0;
      end
    end
  end

endmodule

/* rtl/windowed_median_filter_unit.sv */
// Windowed median filter: a line store, a sliding window and three channel lanes.
// An accepted word passes the read states RD1 and RD2; if it completes a window, the
// lanes then rank one window element per cycle in the SORT state and FIN loads the result.
// No word is taken before the return to IDLE; FIN waits until the output register is free.
// Reset: asynchronous, active low; afterwards a clearing pass over all MAX_WIDTH
// addresses zeroes the line store, during which no input word is taken.
module windowed_median_filter_unit #(
  parameter int MAX_WIDTH = wmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WIN   = wmf_pkg::MAX_WIN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          frame_start_i,
  input  logic [7:0]                    pixel_c0_i,
  input  logic [7:0]                    pixel_c1_i,
  input  logic [7:0]                    pixel_c2_i,
  // Filtered output.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [9:0]                    out_col_o,
  output logic [15:0]                   out_row_o,
  output logic [7:0]                    median_c0_o,
  output logic [7:0]                    median_c1_o,
  output logic [7:0]                    median_c2_o,
  output logic                          last_of_frame_o
);
  import wmf_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int NW    = MAX_WIN * MAX_WIN;
  localparam int IW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int CNT_W = $clog2(NW + 1);
  // Rows held in the line store per column; at least one so the memory has a width.
  localparam int LS    = (MAX_WIN > 1) ? MAX_WIN - 1 : 1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD1   = 6'b000100,
    ST_RD2   = 6'b001000,
    ST_SORT  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers, writable only while no word is in flight.
  logic [10:0] img_w_q;
  logic [15:0] img_h_q;
  logic [2:0]  win_w_q, win_h_q, ctr_x_q, ctr_y_q;
  logic        color_q;

  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_W_RST;
      img_h_q <= IMG_H_RST;
      win_w_q <= WIN_RST;
      win_h_q <= WIN_RST;
      ctr_x_q <= CTR_RST;
      ctr_y_q <= CTR_RST;
      color_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   img_w_q <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        CFG_WINDOW_WIDTH:  win_w_q <= cfg_data_i[2:0];
        CFG_WINDOW_HEIGHT: win_h_q <= cfg_data_i[2:0];
        CFG_CENTER_X:      ctr_x_q <= cfg_data_i[2:0];
        CFG_CENTER_Y:      ctr_y_q <= cfg_data_i[2:0];
        CFG_COLOR_MODE:    color_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, oversized values clamp to the limits.
  logic [10:0] w_eff;
  logic [15:0] h_eff;
  logic [2:0]  ww_eff, wh_eff, cx_eff, cy_eff;

  always_comb begin
    if (img_w_q == '0) begin
      w_eff = 11'd1;
    end else if (32'(img_w_q) > MAX_WIDTH) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = img_w_q;
    end
    h_eff = (img_h_q == '0) ? 16'd1 : img_h_q;
    if (win_w_q == '0) begin
      ww_eff = 3'd1;
    end else if (32'(win_w_q) > MAX_WIN) begin
      ww_eff = 3'(MAX_WIN);
    end else begin
      ww_eff = win_w_q;
    end
    if (win_h_q == '0) begin
      wh_eff = 3'd1;
    end else if (32'(win_h_q) > MAX_WIN) begin
      wh_eff = 3'(MAX_WIN);
    end else begin
      wh_eff = win_h_q;
    end
    cx_eff = (ctr_x_q < ww_eff) ? ctr_x_q : ww_eff - 3'd1;
    cy_eff = (ctr_y_q < wh_eff) ? ctr_y_q : wh_eff - 3'd1;
  end

  // Position tracking and the word being processed.
  logic [AW-1:0]     clr_q;
  logic [AW-1:0]     cnt_col_q, col_q;
  logic [ROW_W-1:0]  cnt_row_q, row_q;
  logic [WORD_W-1:0] px_q;
  logic              in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Line store: row r of a column sits at bits [WORD_W*r +: WORD_W].
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_W*LS-1:0] ram_wdata, ram_rdata;

  wmf_ram #(
    .Width(WORD_W * LS),
    .Depth(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // Column vector: entry 0 is the current row, entry k is k rows above.
  logic [WORD_W-1:0] vcol [MAX_WIN];

  always_comb begin
    vcol[0] = px_q;
    for (int k = 1; k < MAX_WIN; k++) begin
      vcol[k] = ram_rdata[WORD_W*(k-1) +: WORD_W];
    end
    ram_wdata = '0;
    ram_wdata[WORD_W-1:0] = px_q;
    for (int k = 1; k < LS; k++) begin
      ram_wdata[WORD_W*k +: WORD_W] = ram_rdata[WORD_W*(k-1) +: WORD_W];
    end
    if (state_q == ST_CLEAR) begin
      ram_wdata = '0;
    end
  end

  assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_RD2);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : col_q;

  // Window registers, element j*MAX_WIN + k holds column age j and row age k.
  logic [WORD_W-1:0] win_q [NW];
  logic [NW-1:0]     mask_q, mask_d;

  always_comb begin
    for (int j = 0; j < MAX_WIN; j++) begin
      for (int k = 0; k < MAX_WIN; k++) begin
        mask_d[j*MAX_WIN+k] = (32'(j) < 32'(ww_eff)) && (32'(k) < 32'(wh_eff));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NW; e++) begin
        win_q[e] <= '0;
      end
    end else if (state_q == ST_RD2) begin
      for (int j = 0; j < MAX_WIN; j++) begin
        for (int k = 0; k < MAX_WIN; k++) begin
          if (j == 0) begin
            win_q[k] <= vcol[k];
          end else begin
            win_q[j*MAX_WIN+k] <= win_q[(j-1)*MAX_WIN+k];
          end
        end
      end
    end
  end

  // Decisions taken when the column vector arrives.
  logic             emit, col_end, row_end;
  logic [CNT_W-1:0] n_elem;

  assign col_end = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign row_end = (32'(row_q) + 32'd1) >= 32'(h_eff);
  assign emit    = ((32'(col_q) + 32'd1) >= 32'(ww_eff)) &&
                   ((32'(row_q) + 32'd1) >= 32'(wh_eff));
  assign n_elem  = CNT_W'(ww_eff) * CNT_W'(wh_eff);

  // Pending result fields and median positions.
  logic [COL_OUT_W-1:0] pcol_q;
  logic [ROW_W-1:0]     prow_q;
  logic                 plast_q, pcolor_q;
  logic [CNT_W-1:0]     plo_q, phi_q;
  logic [IW-1:0]        idx_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD2) begin
      mask_q   <= mask_d;
      pcol_q   <= COL_OUT_W'(32'(col_q) - 32'(ww_eff) + 32'd1 + 32'(cx_eff));
      prow_q   <= ROW_W'(32'(row_q) - 32'(wh_eff) + 32'd1 + 32'(cy_eff));
      plast_q  <= col_end && row_end;
      pcolor_q <= color_q;
      // Upper and lower middle positions; they are equal for an odd count.
      phi_q    <= n_elem >> 1;
      plo_q    <= (n_elem >> 1) - CNT_W'(!n_elem[0]);
    end
    if (in_acc) begin
      px_q <= {pixel_c2_i, pixel_c1_i, pixel_c0_i};
    end
  end

  // Channel lanes.
  pix_t lane_elems [NUM_CH][NW];
  pix_t lane_lo [NUM_CH];
  pix_t lane_hi [NUM_CH];
  pix_t med [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int e = 0; e < NW; e++) begin
        lane_elems[c][e] = win_q[e][PIX_W*c +: PIX_W];
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    wmf_lane #(
      .NumElem(NW)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (state_q == ST_SORT),
      .idx_i (idx_q),
      .elems_i(lane_elems[c]),
      .mask_i(mask_q),
      .p_lo_i(plo_q),
      .p_hi_i(phi_q),
      .lo_o  (lane_lo[c]),
      .hi_o  (lane_hi[c])
    );
  end

  wmf_merge u_merge (
    .lo_i   (lane_lo),
    .hi_i   (lane_hi),
    .color_i(pcolor_q),
    .med_o  (med)
  );

  // Output register; it frees the sequencer while a result waits to be taken.
  logic out_valid_q, out_load;

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_o       <= pcol_q;
      out_row_o       <= prow_q;
      median_c0_o     <= med[0];
      median_c1_o     <= med[1];
      median_c2_o     <= med[2];
      last_of_frame_o <= plast_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(MAX_WIDTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = emit ? ST_SORT : ST_IDLE;
      ST_SORT:  if (idx_q == IW'(NW - 1)) state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      idx_q     <= '0;
      cnt_col_q <= '0;
      cnt_row_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ST_SORT) begin
        idx_q <= idx_q + IW'(1);
      end else begin
        idx_q <= '0;
      end
      if (in_acc) begin
        col_q <= frame_start_i ? '0 : cnt_col_q;
        row_q <= frame_start_i ? '0 : cnt_row_q;
      end
      if (state_q == ST_RD2) begin
        if (col_end) begin
          cnt_col_q <= '0;
          cnt_row_q <= row_end ? '0 : row_q + ROW_W'(1);
        end else begin
          cnt_col_q <= col_q + AW'(1);
          cnt_row_q <= row_q;
        end
      end
    end
  end

endmodule

/* rtl/wmf_checker.sv */
// Port-level checks of the windowed median filter, bound to its top level.
// Depends on windowed_median_filter_unit.
module wmf_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [9:0] out_col_o,
  input logic [7:0] median_c0_o
);

  // A result word that is not taken holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_col_o) &&
                                    $stable(median_c0_o))
    else $error("stalled result word changed");

  // An accepted word keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a word");

  // A new result only appears after the block was busy with a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the block was idle");

endmodule

bind windowed_median_filter_unit wmf_props u_wmf_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_col_o  (out_col_o),
  .median_c0_o(median_c0_o)
);
